// ----- rtl/rhat_pkg.sv -----
// shared constants, types and helpers for the robin hood address table
package rhat_pkg;

    // slot count, a power of two so the home slot is a mask of the hash
    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int DIST_CW     = SLOT_W + 1;
    localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);
    localparam int KEY_W       = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    localparam int OUT_W       = 1 + SLOT_W + STATUS_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // fmix32 multipliers
    localparam logic [KEY_W-1:0] MIX_C1 = 32'h85eb_ca6b;
    localparam logic [KEY_W-1:0] MIX_C2 = 32'hc2b2_ae35;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef struct packed {
        logic             rd_en;
        slot_idx_t        rd_idx;
        logic             wr_en;
        slot_idx_t        wr_idx;
        logic [KEY_W-1:0] wr_key;
        slot_idx_t        wr_dist;
        logic             set_en;
        slot_idx_t        set_idx;
        logic             clr_en;
        slot_idx_t        clr_idx;
    } store_ctl_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        slot_idx_t        distance;
    } store_rsp_t;

    function automatic slot_idx_t next_slot(slot_idx_t i);
        if (i == slot_idx_t'(TABLE_SLOTS - 1))
            return '0;
        else
            return i + slot_idx_t'(1);
    endfunction

endpackage

// ----- rtl/robin_hood_address_table.sv -----
// top level: command sequencer for the robin hood address table
// sequence: hash the address, then read and evaluate each probed slot in turn (one memory read port);
//   remove then shifts later entries of the run back one slot until the run ends, and the result is posted
// flow: s_axis_tready is low from accept until the result is registered, so one transaction is
//   handled at a time; a stalled result holds the block in its done step
// reset clears all valid bits, the entry count and the max probe distance, not the memory
module robin_hood_address_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rhat_pkg::KEY_W-1:0]         s_axis_tdata,  // address
    input  logic [rhat_pkg::CMD_W-1:0]         s_axis_tuser,  // command
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rhat_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // found, slot, status, entry_count
);
    import rhat_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_HASH    = 7'b0000010,
        S_RD      = 7'b0000100,
        S_EVAL    = 7'b0001000,
        S_RM_RD   = 7'b0010000,
        S_RM_EVAL = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t                  state_reg,   state_next;
    logic [CMD_W-1:0]        cmd_reg,     cmd_next;
    logic [KEY_W-1:0]        addr_reg,    addr_next;
    logic [KEY_W-1:0]        key_reg,     key_next;
    slot_idx_t               idx_reg,     idx_next;
    logic [DIST_CW-1:0]      d_reg,       d_next;
    logic                    placed_reg,  placed_next;
    logic                    found_reg,   found_next;
    slot_idx_t               slot_reg,    slot_next;
    logic [STATUS_W-1:0]     status_reg,  status_next;
    logic [COUNT_W-1:0]      count_reg,   count_next;
    slot_idx_t               max_reg,     max_next;
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]  m_data_reg,  m_data_next;

    logic       accept;
    logic       hash_done;
    slot_idx_t  home;
    store_ctl_t ctl;
    store_rsp_t rsp;
    slot_idx_t  nx_idx;
    logic       is_ins;
    logic       is_rm;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign nx_idx        = next_slot(idx_reg);
    assign is_ins        = (cmd_reg == CMD_INSERT);
    assign is_rm         = (cmd_reg == CMD_REMOVE);

    rhat_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (s_axis_tdata),
        .done  (hash_done),
        .home  (home)
    );

    rhat_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        d_next       = d_reg;
        placed_next  = placed_reg;
        found_next   = found_reg;
        slot_next    = slot_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        max_next     = max_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ctl          = '0;

        if (m_axis_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = s_axis_tuser;
                    addr_next   = s_axis_tdata;
                    found_next  = 1'b0;
                    slot_next   = '0;
                    status_next = STATUS_OK;
                    state_next  = S_HASH;
                end
            end

            S_HASH:
            begin
                if (hash_done)
                begin
                    idx_next    = home;
                    d_next      = '0;
                    placed_next = 1'b0;
                    key_next    = addr_reg;
                    if (is_ins && count_reg >= COUNT_W'(TABLE_SLOTS))
                    begin
                        status_next = STATUS_FULL;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_RD;
                end
            end

            S_RD:
            begin
                // probing stops once the distance passes the largest one stored
                if (!is_ins && d_reg > DIST_CW'(max_reg))
                begin
                    status_next = STATUS_MISS;
                    state_next  = S_DONE;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_idx = idx_reg;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (is_ins)
                begin
                    if (!rsp.valid || d_reg > DIST_CW'(rsp.distance))
                    begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_idx  = idx_reg;
                        ctl.wr_key  = key_reg;
                        ctl.wr_dist = d_reg[SLOT_W-1:0];
                        if (d_reg > DIST_CW'(max_reg))
                            max_next = d_reg[SLOT_W-1:0];
                        if (!placed_reg)
                        begin
                            slot_next   = idx_reg;
                            placed_next = 1'b1;
                        end
                    end
                    if (!rsp.valid)
                    begin
                        ctl.set_en  = 1'b1;
                        ctl.set_idx = idx_reg;
                        count_next  = count_reg + COUNT_W'(1);
                        state_next  = S_DONE;
                    end
                    else if (d_reg > DIST_CW'(rsp.distance))
                    begin
                        // evicted entry carries on from the next slot
                        key_next   = rsp.key;
                        d_next     = DIST_CW'(rsp.distance) + DIST_CW'(1);
                        idx_next   = nx_idx;
                        state_next = S_RD;
                    end
                    else
                    begin
                        d_next     = d_reg + DIST_CW'(1);
                        idx_next   = nx_idx;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (!rsp.valid)
                    begin
                        status_next = STATUS_MISS;
                        state_next  = S_DONE;
                    end
                    else if (rsp.key == addr_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = idx_reg;
                        if (is_rm)
                        begin
                            ctl.clr_en  = 1'b1;
                            ctl.clr_idx = idx_reg;
                            count_next  = count_reg - COUNT_W'(1);
                            d_next      = DIST_CW'(1);
                            state_next  = S_RM_RD;
                        end
                        else
                            state_next = S_DONE;
                    end
                    else if (d_reg > DIST_CW'(rsp.distance))
                    begin
                        status_next = STATUS_MISS;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        d_next     = d_reg + DIST_CW'(1);
                        idx_next   = nx_idx;
                        state_next = S_RD;
                    end
                end
            end

            S_RM_RD:
            begin
                // d_reg counts shift steps here
                if (d_reg == DIST_CW'(TABLE_SLOTS))
                    state_next = S_DONE;
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_idx = nx_idx;
                    state_next = S_RM_EVAL;
                end
            end

            S_RM_EVAL:
            begin
                if (!rsp.valid || rsp.distance == '0)
                    state_next = S_DONE;
                else
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_idx  = idx_reg;
                    ctl.wr_key  = rsp.key;
                    ctl.wr_dist = rsp.distance - slot_idx_t'(1);
                    ctl.set_en  = 1'b1;
                    ctl.set_idx = idx_reg;
                    ctl.clr_en  = 1'b1;
                    ctl.clr_idx = nx_idx;
                    idx_next    = nx_idx;
                    d_next      = d_reg + DIST_CW'(1);
                    state_next  = S_RM_RD;
                end
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_TDATA_W'({count_reg, status_reg, slot_reg, found_reg});
                    state_next   = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        addr_reg   <= addr_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        d_reg      <= d_next;
        placed_reg <= placed_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(TABLE_SLOTS))
        else $error("entry count above table size");

    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> max_reg >= $past(max_reg))
        else $error("max probe distance decreased");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> (state_reg == S_EVAL || state_reg == S_RM_EVAL))
        else $error("slot memory written outside an evaluate step");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status_reg == STATUS_FULL) |-> count_reg == COUNT_W'(TABLE_SLOTS))
        else $error("full status with free slots");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result posted outside the done step");
`endif

endmodule

// ----- rtl/rhat_hash.sv -----
// fmix32 home slot hash on one shared 32x32 multiplier, two passes
module rhat_hash (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rhat_pkg::KEY_W-1:0] key,
    output logic                       done,
    output rhat_pkg::slot_idx_t        home
);
    import rhat_pkg::*;

    typedef enum logic [2:0] {
        HS_IDLE = 3'b001,
        HS_MUL2 = 3'b010,
        HS_DONE = 3'b100
    } hstate_t;

    hstate_t          state_reg;
    hstate_t          state_next;
    logic [KEY_W-1:0] h_reg;
    logic [KEY_W-1:0] mul_a;
    logic [KEY_W-1:0] mul_b;
    logic [KEY_W-1:0] prod;
    logic [KEY_W-1:0] h_final;

    // first pass takes the key straight from the input transaction
    always_comb
    begin
        if (state_reg == HS_MUL2)
        begin
            mul_a = h_reg ^ (h_reg >> 13);
            mul_b = MIX_C2;
        end
        else
        begin
            mul_a = key ^ (key >> 16);
            mul_b = MIX_C1;
        end
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        unique case (state_reg)
            HS_IDLE: state_next = start ? HS_MUL2 : HS_IDLE;
            HS_MUL2: state_next = HS_DONE;
            HS_DONE: state_next = HS_IDLE;
            default: state_next = HS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= HS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (start || state_reg == HS_MUL2)
            h_reg <= prod;
    end

    assign h_final = h_reg ^ (h_reg >> 16);
    assign home    = h_final[SLOT_W-1:0];
    assign done    = (state_reg == HS_DONE);

endmodule

// ----- rtl/rhat_store.sv -----
// slot memory for key and distance, plus the per-slot valid flops
module rhat_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rhat_pkg::store_ctl_t ctl,
    output rhat_pkg::store_rsp_t rsp
);
    import rhat_pkg::*;

    logic [KEY_W+SLOT_W-1:0] mem [TABLE_SLOTS];
    logic [KEY_W+SLOT_W-1:0] rdata_reg;
    logic                    rvalid_reg;
    logic [TABLE_SLOTS-1:0]  valid_reg;
    logic [TABLE_SLOTS-1:0]  valid_next;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[ctl.wr_idx] <= {ctl.wr_key, ctl.wr_dist};
        if (ctl.rd_en)
        begin
            rdata_reg  <= mem[ctl.rd_idx];
            rvalid_reg <= valid_reg[ctl.rd_idx];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clr_en)
            valid_next[ctl.clr_idx] = 1'b0;
        if (ctl.set_en)
            valid_next[ctl.set_idx] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign rsp = {rvalid_reg, rdata_reg};

endmodule
